### design/blp_pkg.sv
package blp_pkg;

	// Port width of a coordinate field; fixed by the channel format
	localparam int PORT_COORD_W = 6;
	localparam int COLOR_W      = 24;
	// Coordinate bits actually used inside the tile (2 to 6)
	localparam int COORD_BITS   = 6;

	typedef logic [PORT_COORD_W-1:0] port_coord_t;
	typedef logic [COORD_BITS-1:0]   coord_t;
	typedef logic [COLOR_W-1:0]      color_t;
	// Error term: covers +/- 2 * (2^COORD_BITS - 1)
	typedef logic signed [COORD_BITS+1:0] err_t;

	typedef struct packed {
		logic load;     // capture endpoints and colour
		logic setup;    // order endpoints, pick major axis, seed error term
		logic advance;  // step to the next pixel
	} blp_cmd_t;

	typedef struct packed {
		logic zero_len; // no pixels to draw
		logic last;     // current pixel is the final one
	} blp_sts_t;

endpackage

### design/blp_if.sv
interface blp_seg_if
	import blp_pkg::*;
();
	logic        valid;
	logic        ready;
	port_coord_t start_x;
	port_coord_t start_y;
	port_coord_t end_x;
	port_coord_t end_y;
	color_t      line_color;

	modport source (output valid, start_x, start_y, end_x, end_y, line_color, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, line_color, output ready);
endinterface

interface blp_pix_if
	import blp_pkg::*;
();
	logic        valid;
	logic        ready;
	port_coord_t pixel_x;
	port_coord_t pixel_y;
	color_t      pixel_color;
	logic        last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

### design/blp_ctrl.sv
module blp_ctrl
	import blp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  blp_sts_t sts,
	output blp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_RUN   = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.zero_len ? ST_IDLE : ST_RUN;
			end
			ST_RUN: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.advance = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/blp_dp.sv
module blp_dp
	import blp_pkg::*;
(
	input  logic        clk,
	input  blp_cmd_t    cmd,
	output blp_sts_t    sts,
	input  port_coord_t start_x,
	input  port_coord_t start_y,
	input  port_coord_t end_x,
	input  port_coord_t end_y,
	input  color_t      line_color,
	output port_coord_t pixel_x,
	output port_coord_t pixel_y,
	output color_t      pixel_color,
	output logic        last_pixel
);

	coord_t x1_q, y1_q, x2_q, y2_q;
	color_t color_q;

	coord_t mj_q, mn_q, cnt_q;
	logic   xmaj_q, neg_q;
	err_t   err_q, inc_q, dec_q;

	// setup terms
	coord_t adx, ady, bx, by, ex, ey, maj_len, min_len;
	logic   xmaj, swap, neg;
	err_t   two_min, two_maj;

	always_comb begin
		adx     = (x2_q > x1_q) ? x2_q - x1_q : x1_q - x2_q;
		ady     = (y2_q > y1_q) ? y2_q - y1_q : y1_q - y2_q;
		xmaj    = adx > ady;
		swap    = xmaj ? !(x2_q > x1_q) : !(y2_q > y1_q);
		bx      = swap ? x2_q : x1_q;
		by      = swap ? y2_q : y1_q;
		ex      = swap ? x1_q : x2_q;
		ey      = swap ? y1_q : y2_q;
		maj_len = xmaj ? adx : ady;
		min_len = xmaj ? ady : adx;
		neg     = xmaj ? (ey < by) : (ex < bx);
		two_min = {1'b0, min_len, 1'b0};
		two_maj = {1'b0, maj_len, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q    <= start_x[COORD_BITS-1:0];
			y1_q    <= start_y[COORD_BITS-1:0];
			x2_q    <= end_x[COORD_BITS-1:0];
			y2_q    <= end_y[COORD_BITS-1:0];
			color_q <= line_color;
		end
		if (cmd.setup) begin
			xmaj_q <= xmaj;
			neg_q  <= neg;
			mj_q   <= xmaj ? bx : by;
			mn_q   <= xmaj ? by : bx;
			cnt_q  <= maj_len;
			err_q  <= two_min - err_t'({2'b00, maj_len});
			inc_q  <= two_min;
			dec_q  <= two_min - two_maj;
		end else if (cmd.advance) begin
			if (err_q > err_t'(0)) begin
				mn_q  <= neg_q ? mn_q - coord_t'(1) : mn_q + coord_t'(1);
				err_q <= err_q + dec_q;
			end else begin
				err_q <= err_q + inc_q;
			end
			mj_q  <= mj_q + coord_t'(1);
			cnt_q <= cnt_q - coord_t'(1);
		end
	end

	assign sts.zero_len = (maj_len == '0);
	assign sts.last     = (cnt_q == coord_t'(1));

	assign pixel_x     = port_coord_t'(xmaj_q ? mj_q : mn_q);
	assign pixel_y     = port_coord_t'(xmaj_q ? mn_q : mj_q);
	assign pixel_color = color_q;
	assign last_pixel  = sts.last;

endmodule

### design/bresenham_line_pixels.sv
// Channel  Role   Transfer carries
// seg      sink   start_x, start_y, end_x, end_y (6 b each), line_color (24 b)
// pix      source pixel_x, pixel_y (6 b each), pixel_color (24 b), last_pixel
//
// A segment is handled in order: capture, then ordering the endpoints and
// seeding the error term, then one pixel per cycle from the stepping
// datapath while pix is ready. A zero-length segment ends after setup.
// One segment at a time: seg.ready is high only while the block is idle.
// pix stalls simply hold the current pixel; reset returns the controller to
// idle, with no clearing pass.
module bresenham_line_pixels
	import blp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	blp_seg_if.sink   seg,
	blp_pix_if.source pix
);

	blp_cmd_t cmd;
	blp_sts_t sts;

	// sequencing: idle -> setup -> run (one pixel per pix transfer)
	blp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// endpoint ordering, error term and pixel stepping
	blp_dp u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.start_x     (seg.start_x),
		.start_y     (seg.start_y),
		.end_x       (seg.end_x),
		.end_y       (seg.end_y),
		.line_color  (seg.line_color),
		.pixel_x     (pix.pixel_x),
		.pixel_y     (pix.pixel_y),
		.pixel_color (pix.pixel_color),
		.last_pixel  (pix.last_pixel)
	);

	// never take a new segment while pixels are still on offer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> !seg.ready)
		else $error("segment accepted while pixels pending");

	// a segment transfer is followed by the setup cycle, with no pixel shown
	a_setup_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(seg.valid && seg.ready) |=> !pix.valid)
		else $error("pixel shown during setup");

	// the final pixel ends the line
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && pix.last_pixel) |=> (!pix.valid && seg.ready))
		else $error("pixels continue after last_pixel");

	// a non-final pixel transfer is followed by another pixel
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready && !pix.last_pixel) |=> pix.valid)
		else $error("line ended without last_pixel");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import blp_pkg::*;

	// Longest stretch with no transfer on either channel before the run is
	// declared hung. The deliberate receiver hold-off is the longest quiet
	// period in a correct run, so this sits well above it.
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	// Settling time after the last expected pixel: a full-length segment
	// plus its capture and setup, with margin.
	localparam int DRAIN_CYCLES = 80;
	localparam int COORD_MASK   = (1 << COORD_BITS) - 1;
	localparam int COORD_MAX    = (1 << PORT_COORD_W) - 1;

	typedef struct {
		port_coord_t sx;
		port_coord_t sy;
		port_coord_t ex;
		port_coord_t ey;
		color_t      color;
	} segment_t;

	typedef struct {
		port_coord_t x;
		port_coord_t y;
		color_t      color;
		logic        last;
	} pixel_t;

	logic clk;
	logic arst_n = 1'b0;

	blp_seg_if seg_bus ();
	blp_pix_if pix_bus ();

	bresenham_line_pixels dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg_bus.sink),
		.pix    (pix_bus.source)
	);

	// Pixels predicted for accepted segments, oldest first
	pixel_t pixels_due[$];
	int     mismatches  = 0;
	int     quiet_count = 0;

	// Idling controls shared by the stimulus, the receiver and the tests
	bit seg_gaps_on  = 1'b1;
	bit pix_stalls_on = 1'b1;
	bit hold_req     = 1'b0;  // ask the receiver for one long hold-off
	bit hold_active  = 1'b0;  // receiver has started that hold-off

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
		end
	endtask

	// ------------------------------------------------------------------
	// Line rasteriser: works out every pixel of one segment and queues them.
	// Endpoints are masked to the tile's coordinate width first. The major
	// axis is x only when |dx| is strictly larger, so diagonals walk in y.
	// The walk starts at the endpoint with the smaller major coordinate and
	// stops one short of the far end; the minor axis moves only when the
	// error term is strictly positive.
	// ------------------------------------------------------------------
	function automatic void rasterise(input segment_t s);
		int     x1, y1, x2, y2;
		int     adx, ady;
		int     mj, mn, mj_end, mn_end;
		int     span, drift, dir, err;
		bit     x_major;
		pixel_t p;

		x1 = int'(s.sx) & COORD_MASK;
		y1 = int'(s.sy) & COORD_MASK;
		x2 = int'(s.ex) & COORD_MASK;
		y2 = int'(s.ey) & COORD_MASK;
		adx = (x2 > x1) ? x2 - x1 : x1 - x2;
		ady = (y2 > y1) ? y2 - y1 : y1 - y2;
		x_major = (adx > ady);

		// order the endpoints along the major axis
		if (x_major ? (x2 > x1) : (y2 > y1)) begin
			mj = x_major ? x1 : y1;
			mn = x_major ? y1 : x1;
			mj_end = x_major ? x2 : y2;
			mn_end = x_major ? y2 : x2;
		end else begin
			mj = x_major ? x2 : y2;
			mn = x_major ? y2 : x2;
			mj_end = x_major ? x1 : y1;
			mn_end = x_major ? y1 : x1;
		end

		span  = mj_end - mj;
		drift = mn_end - mn;
		dir   = 1;
		if (drift < 0) begin
			dir   = -1;
			drift = -drift;
		end
		err = 2 * drift - span;

		for (int k = 0; k < span; k++) begin
			p.x     = port_coord_t'((x_major ? mj : mn) & COORD_MASK);
			p.y     = port_coord_t'((x_major ? mn : mj) & COORD_MASK);
			p.color = s.color;
			p.last  = (k == span - 1);
			pixels_due.push_back(p);
			if (err > 0) begin
				mn  += dir;
				err += 2 * drift - 2 * span;
			end else begin
				err += 2 * drift;
			end
			mj += 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Segment sender: optional random gap, then offer until the transfer.
	// valid stays high between back-to-back segments; only the payload moves.
	// ------------------------------------------------------------------
	task automatic send_segment(input port_coord_t sx, input port_coord_t sy,
			input port_coord_t ex, input port_coord_t ey, input color_t color);
		segment_t s;

		s = '{sx, sy, ex, ey, color};
		if (seg_gaps_on && $urandom_range(0, 3) == 0) begin
			seg_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		seg_bus.valid      <= 1'b1;
		seg_bus.start_x    <= sx;
		seg_bus.start_y    <= sy;
		seg_bus.end_x      <= ex;
		seg_bus.end_y      <= ey;
		seg_bus.line_color <= color;
		@(posedge clk);
		while (!seg_bus.ready) @(posedge clk);
		rasterise(s);
	endtask

	// A coordinate a few steps from c, kept inside the tile
	function automatic port_coord_t near_coord(input port_coord_t c);
		int v;

		v = int'(c) + int'($urandom_range(0, 8)) - 4;
		if (v < 0) v = 0;
		if (v > COORD_MAX) v = COORD_MAX;
		return port_coord_t'(v);
	endfunction

	function automatic segment_t random_segment();
		segment_t s;

		s.sx    = port_coord_t'($urandom_range(0, COORD_MAX));
		s.sy    = port_coord_t'($urandom_range(0, COORD_MAX));
		s.ex    = port_coord_t'($urandom_range(0, COORD_MAX));
		s.ey    = port_coord_t'($urandom_range(0, COORD_MAX));
		s.color = color_t'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				// degenerate: both ends the same, no pixels
				s.ex = s.sx;
				s.ey = s.sy;
			end
			1, 2: begin
				s.ex = near_coord(s.sx);
				s.ey = near_coord(s.sy);
			end
			3: begin
				// axis-aligned
				if ($urandom_range(0, 1)) s.ey = s.sy;
				else s.ex = s.sx;
			end
			default: ;
		endcase
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Extremes of the tile, both walking directions on each axis, ties,
	// single-pixel lines, zero-length lines and a zero starting error term.
	task automatic test_directed();
		send_segment(6'd5,  6'd5,  6'd5,  6'd5,  24'h000000); // zero length
		send_segment(6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF); // zero length, corner
		send_segment(6'd0,  6'd0,  6'd63, 6'd0,  24'hFFFFFF); // full horizontal
		send_segment(6'd63, 6'd0,  6'd0,  6'd0,  24'h000000); // horizontal, reversed
		send_segment(6'd0,  6'd0,  6'd0,  6'd63, 24'hAAAAAA); // full vertical
		send_segment(6'd0,  6'd63, 6'd0,  6'd0,  24'h555555); // vertical, reversed
		send_segment(6'd0,  6'd0,  6'd63, 6'd63, 24'h0F0F0F); // diagonal: y major
		send_segment(6'd63, 6'd0,  6'd0,  6'd63, 24'hF0F0F0); // anti-diagonal
		send_segment(6'd0,  6'd0,  6'd1,  6'd0,  24'h123456); // one pixel, x major
		send_segment(6'd0,  6'd0,  6'd1,  6'd1,  24'h654321); // one pixel, tie
		send_segment(6'd0,  6'd0,  6'd4,  6'd2,  24'h800001); // error starts at zero
		send_segment(6'd0,  6'd0,  6'd63, 6'd1,  24'h7FFFFE); // shallowest slope
		send_segment(6'd0,  6'd63, 6'd1,  6'd0,  24'hC3C3C3); // steep, minor steps down
		send_segment(6'd63, 6'd10, 6'd0,  6'd20, 24'h3C3C3C); // x major, reversed
		send_segment(6'd10, 6'd40, 6'd50, 6'd5,  24'h00FF00); // x major, minor down
		send_segment(6'd62, 6'd1,  6'd1,  6'd62, 24'hFF00FF); // tie, minor down
		send_segment(6'd21, 6'd42, 6'd42, 6'd21, 24'h2A2A2A); // alternating bits
		send_segment(6'd63, 6'd63, 6'd0,  6'd62, 24'hD5D5D5);
		send_segment(6'd32, 6'd0,  6'd31, 6'd63, 24'h000001);
	endtask

	task automatic test_random(input int count);
		segment_t s;

		repeat (count) begin
			s = random_segment();
			send_segment(s.sx, s.sy, s.ex, s.ey, s.color);
		end
	endtask

	// Receiver holds off for a long stretch while long segments keep coming,
	// so the block sits on a pixel and refuses the next segment.
	task automatic test_pixel_backpressure(input int count);
		hold_req = 1'b1;
		while (!hold_active) @(posedge clk);
		repeat (count) begin
			send_segment(port_coord_t'($urandom_range(0, 7)),
				port_coord_t'($urandom_range(0, COORD_MAX)),
				port_coord_t'($urandom_range(56, COORD_MAX)),
				port_coord_t'($urandom_range(0, COORD_MAX)),
				color_t'($urandom));
		end
	endtask

	// Last part: no idling anywhere, segments back to back
	task automatic test_full_rate(input int count);
		seg_gaps_on   = 1'b0;
		pix_stalls_on = 1'b0;
		test_random(count);
	endtask

	// ------------------------------------------------------------------
	// Pixel receiver: random stall bursts between ready stretches of random
	// length, occasionally a long clean stretch, plus the one long hold-off.
	// ------------------------------------------------------------------
	initial begin
		pix_bus.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				pix_bus.ready <= 1'b0;
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req    = 1'b0;
				hold_active = 1'b0;
			end else if (pix_stalls_on && $urandom_range(0, 2) == 0) begin
				pix_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			pix_bus.ready <= 1'b1;
			if (!pix_stalls_on) @(posedge clk);
			else if ($urandom_range(0, 5) == 0) repeat (60) @(posedge clk);
			else repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Pixel checker: every pixel transfer against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_pixels
		pixel_t want;

		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			if (pixels_due.size() == 0) begin
				flag_mismatch($sformatf("pixel (%0d,%0d) with none expected",
					pix_bus.pixel_x, pix_bus.pixel_y));
			end else begin
				want = pixels_due.pop_front();
				compare_field("pixel_x",     pix_bus.pixel_x,     want.x);
				compare_field("pixel_y",     pix_bus.pixel_y,     want.y);
				compare_field("pixel_color", pix_bus.pixel_color, want.color);
				compare_field("last_pixel",  pix_bus.last_pixel,  want.last);
			end
		end
	end

	// Hang detector: consecutive cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (seg_bus.valid && seg_bus.ready) ||
				(pix_bus.valid && pix_bus.ready)) begin
			quiet_count <= 0;
		end else if (quiet_count >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_count <= quiet_count + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		seg_bus.valid      <= 1'b0;
		seg_bus.start_x    <= '0;
		seg_bus.start_y    <= '0;
		seg_bus.end_x      <= '0;
		seg_bus.end_y      <= '0;
		seg_bus.line_color <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(75);
		test_pixel_backpressure(6);
		test_full_rate(12);

		seg_bus.valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
